>>> design/bscff_pkg.sv
package bscff_pkg;

  // Store geometry
  localparam int NBITS   = 1024;
  localparam int WORD_W  = 64;
  localparam int NWORDS  = NBITS / WORD_W;
  localparam int WADDR_W = $clog2(NWORDS);
  localparam int BPOS_W  = $clog2(WORD_W);
  localparam int CNT_W   = $clog2(NBITS) + 1;

  // Field widths
  localparam int OP_W  = 2;
  localparam int IDX_W = 10;
  localparam int CFG_W = 11;

  // Configuration port
  localparam int APB_DW = 32;
  localparam int CFG_AW = 3;
  localparam int REG_W  = CFG_AW - 2;
  localparam logic [REG_W-1:0] REG_BITS_IN_USE = REG_W'(0);
  localparam logic [CFG_W-1:0] BITS_IN_USE_RST = CFG_W'(1024);

  typedef enum logic [OP_W-1:0] {
    OP_SET   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_TEST  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MODIFY,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Lowest set bit position of a word (0 when the word is empty)
  function automatic logic [BPOS_W-1:0] find_first(input logic [WORD_W-1:0] w);
    logic [BPOS_W-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        pos = BPOS_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

>>> design/bscff_if.sv
interface bscff_in_if;
  logic                         valid;
  logic                         ready;
  logic [bscff_pkg::OP_W-1:0]   operation;
  logic [bscff_pkg::IDX_W-1:0]  bit_index;

  modport source (output valid, output operation, output bit_index, input ready);
  modport sink   (input valid, input operation, input bit_index, output ready);
endinterface

interface bscff_out_if;
  logic                         valid;
  logic                         ready;
  logic                         index_ok;
  logic                         bit_value;
  logic [bscff_pkg::IDX_W-1:0]  first_set;
  logic                         set_found;
  logic [bscff_pkg::IDX_W-1:0]  first_zero;
  logic                         zero_found;

  modport source (output valid, output index_ok, output bit_value, output first_set,
                  output set_found, output first_zero, output zero_found, input ready);
  modport sink   (input valid, input index_ok, input bit_value, input first_set,
                  input set_found, input first_zero, input zero_found, output ready);
endinterface

>>> design/bitmap_set_clear_find_first_core.sv
// Bit map with set, clear, test and find-first-set / find-first-zero.
// Takes a new item only in the idle state, once the result of the last one has been loaded
// into the output register. The 1024-bit store sits in a 16 x 64 RAM with one read port;
// after a read-modify-write of the addressed word the scan reads one word per cycle.
// Reset: synchronous, active low; map reads as all zero (per-word valid bits), and
// bits_in_use returns to 1024.
module bitmap_set_clear_find_first_core (
  input  logic                               clk,
  input  logic                               rst_n,
  bscff_in_if.sink                           in_ch,
  bscff_out_if.source                        out_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bscff_pkg::CFG_AW-1:0]       paddr,
  input  logic [bscff_pkg::APB_DW-1:0]       pwdata,
  output logic [bscff_pkg::APB_DW-1:0]       prdata,
  output logic                               pready
);

  localparam int WORD_W  = bscff_pkg::WORD_W;
  localparam int NWORDS  = bscff_pkg::NWORDS;
  localparam int WADDR_W = bscff_pkg::WADDR_W;
  localparam int BPOS_W  = bscff_pkg::BPOS_W;
  localparam int CNT_W   = bscff_pkg::CNT_W;
  localparam int IDX_W   = bscff_pkg::IDX_W;
  localparam int CFG_W   = bscff_pkg::CFG_W;
  localparam int CFG_AW_HI = bscff_pkg::CFG_AW - 1;

  bscff_pkg::state_t state_r, state_nxt;

  logic [CFG_W-1:0]   bits_in_use_r;
  logic [CNT_W-1:0]   used;
  logic [CNT_W-BPOS_W-1:0] used_hi;
  logic [BPOS_W-1:0]  used_lo;

  logic [bscff_pkg::OP_W-1:0] op_r;
  logic [IDX_W-1:0]   idx_r;
  logic               ok_r;
  logic               bitval_r;

  logic [WADDR_W:0]   iss_r;
  logic               dvld_r;
  logic [WADDR_W-1:0] dw_r;
  logic [WADDR_W-1:0] rd_addr_r;
  logic [NWORDS-1:0]  row_vld_r;

  logic [IDX_W-1:0]   fs_r, fz_r;
  logic               fsf_r, fzf_r;

  logic               out_valid_r;
  logic               out_ok_r, out_val_r, out_fsf_r, out_fzf_r;
  logic [IDX_W-1:0]   out_fs_r, out_fz_r;

  logic               in_xfer, cfg_wr, out_load, scan_last, issue;
  logic               ram_we;
  logic [WADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0]  ram_rdata, word_rd, new_word, use_mask, set_word, zero_word;
  logic [BPOS_W-1:0]  bpos;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[CFG_AW_HI:2] == bscff_pkg::REG_BITS_IN_USE) ?
                  bscff_pkg::APB_DW'(bits_in_use_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_in_use_r <= bscff_pkg::BITS_IN_USE_RST;
    end else if (cfg_wr && paddr[CFG_AW_HI:2] == bscff_pkg::REG_BITS_IN_USE) begin
      bits_in_use_r <= pwdata[CFG_W-1:0];
    end
  end

  // Saturate the count at the store size
  always_comb begin
    if (32'(bits_in_use_r) > bscff_pkg::NBITS) begin
      used = CNT_W'(bscff_pkg::NBITS);
    end else begin
      used = CNT_W'(bits_in_use_r);
    end
  end
  assign used_hi = used[CNT_W-1:BPOS_W];
  assign used_lo = used[BPOS_W-1:0];

  // Word store
  assign ram_raddr = (state_r == bscff_pkg::ST_IDLE) ? WADDR_W'(in_ch.bit_index >> BPOS_W)
                                                     : iss_r[WADDR_W-1:0];
  assign ram_we    = (state_r == bscff_pkg::ST_MODIFY) && ok_r;

  bscff_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NWORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rd_addr_r),
    .wdata (new_word),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Words never written read as zero
  assign word_rd = row_vld_r[rd_addr_r] ? ram_rdata : '0;

  // Apply the operation to the addressed word
  assign bpos = idx_r[BPOS_W-1:0];
  always_comb begin
    new_word = word_rd;
    unique case (bscff_pkg::op_t'(op_r))
      bscff_pkg::OP_SET:   new_word[bpos] = 1'b1;
      bscff_pkg::OP_CLEAR: new_word[bpos] = 1'b0;
      bscff_pkg::OP_TEST:  new_word = word_rd;
      default:             new_word = word_rd;
    endcase
  end

  // Keep only bits in use of the word under scan
  always_comb begin
    if (32'(dw_r) < 32'(used_hi)) begin
      use_mask = '1;
    end else if (32'(dw_r) == 32'(used_hi)) begin
      use_mask = ~({WORD_W{1'b1}} << used_lo);
    end else begin
      use_mask = '0;
    end
  end
  assign set_word  = word_rd & use_mask;
  assign zero_word = ~word_rd & use_mask;

  // Sequencer
  assign in_ch.ready = (state_r == bscff_pkg::ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign issue       = (state_r == bscff_pkg::ST_SCAN) && (32'(iss_r) < NWORDS);
  assign scan_last   = dvld_r && (32'(dw_r) == NWORDS - 1);

  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    unique case (state_r)
      bscff_pkg::ST_IDLE: begin
        if (in_xfer) state_nxt = bscff_pkg::ST_MODIFY;
      end
      bscff_pkg::ST_MODIFY: begin
        state_nxt = bscff_pkg::ST_SCAN;
      end
      bscff_pkg::ST_SCAN: begin
        if (scan_last) state_nxt = bscff_pkg::ST_DONE;
      end
      bscff_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = bscff_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bscff_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bscff_pkg::ST_IDLE;
      row_vld_r   <= '0;
      dvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dvld_r  <= issue;
      if (ram_we) begin
        row_vld_r[rd_addr_r] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rd_addr_r <= ram_raddr;
    dw_r      <= iss_r[WADDR_W-1:0];

    // Capture the item
    if (in_xfer) begin
      op_r  <= in_ch.operation;
      idx_r <= in_ch.bit_index;
      ok_r  <= (32'(in_ch.bit_index) < 32'(used));
    end

    // Record the bit and start the scan
    if (state_r == bscff_pkg::ST_MODIFY) begin
      bitval_r <= ok_r && new_word[bpos];
      iss_r    <= '0;
      fs_r     <= '0;
      fz_r     <= '0;
      fsf_r    <= 1'b0;
      fzf_r    <= 1'b0;
    end else if (issue) begin
      iss_r <= iss_r + 1'b1;
    end

    // Fold in one word per cycle
    if (dvld_r && state_r == bscff_pkg::ST_SCAN) begin
      if (!fsf_r && |set_word) begin
        fsf_r <= 1'b1;
        fs_r  <= IDX_W'({dw_r, bscff_pkg::find_first(set_word)});
      end
      if (!fzf_r && |zero_word) begin
        fzf_r <= 1'b1;
        fz_r  <= IDX_W'({dw_r, bscff_pkg::find_first(zero_word)});
      end
    end

    // Hold the result for transfer
    if (out_load) begin
      out_ok_r  <= ok_r;
      out_val_r <= bitval_r;
      out_fs_r  <= fs_r;
      out_fsf_r <= fsf_r;
      out_fz_r  <= fz_r;
      out_fzf_r <= fzf_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.index_ok   = out_ok_r;
  assign out_ch.bit_value  = out_val_r;
  assign out_ch.first_set  = out_fs_r;
  assign out_ch.set_found  = out_fsf_r;
  assign out_ch.first_zero = out_fz_r;
  assign out_ch.zero_found = out_fzf_r;

endmodule

>>> design/bscff_ram.sv
module bscff_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sim/tb_bitmap_set_clear_find_first_core.sv
module tb_bitmap_set_clear_find_first_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OP_W   = bscff_pkg::OP_W;
  localparam int IDX_W  = bscff_pkg::IDX_W;
  localparam int CFG_W  = bscff_pkg::CFG_W;
  localparam int CFG_AW = bscff_pkg::CFG_AW;
  localparam int APB_DW = bscff_pkg::APB_DW;
  localparam int NBITS  = bscff_pkg::NBITS;

  // Operation code with no meaning; the block treats it as a test
  localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;
  localparam logic [CFG_AW-1:0] ADDR_BITS_IN_USE = {bscff_pkg::REG_BITS_IN_USE, 2'b00};
  localparam int LATENCY_WAIT = 30;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int NUM_PHASES   = 11;

  typedef struct packed {
    logic             index_ok;
    logic             bit_value;
    logic [IDX_W-1:0] first_set;
    logic             set_found;
    logic [IDX_W-1:0] first_zero;
    logic             zero_found;
  } bitmap_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [OP_W-1:0]  op;
    logic [CFG_W-1:0] arg;
    bit               typed;
    bitmap_result_t   result;
  } directed_row_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  bscff_in_if  in_if ();
  bscff_out_if out_if ();

  bitmap_set_clear_find_first_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the bit map and of the bits-in-use register
  bit [NBITS-1:0]   bitmap_shadow;
  logic [CFG_W-1:0] bits_in_use_shadow;

  bitmap_result_t pending_results[$];
  directed_row_t  directed_rows[$];

  int  mismatch_count;
  int  items_sent;
  int  results_checked;
  int  cfg_writes;
  int  cycle_count;
  bit  no_idle;

  // Compute the result of one item and update the shadow map
  function automatic bitmap_result_t predict_bit_access(logic [OP_W-1:0] op,
                                                        logic [IDX_W-1:0] idx);
    bitmap_result_t r;
    int used;
    r = '0;
    used = (int'(bits_in_use_shadow) > NBITS) ? NBITS : int'(bits_in_use_shadow);
    if (int'(idx) < used) begin
      r.index_ok = 1'b1;
      if (op == bscff_pkg::OP_SET) begin
        bitmap_shadow[idx] = 1'b1;
      end else if (op == bscff_pkg::OP_CLEAR) begin
        bitmap_shadow[idx] = 1'b0;
      end
      r.bit_value = bitmap_shadow[idx];
    end
    for (int i = 0; i < used; i++) begin
      if (bitmap_shadow[i] && !r.set_found) begin
        r.first_set = IDX_W'(i);
        r.set_found = 1'b1;
      end
      if (!bitmap_shadow[i] && !r.zero_found) begin
        r.first_zero = IDX_W'(i);
        r.zero_found = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic bitmap_result_t mk_result(logic ok, logic val, int fs, logic sf,
                                               int fz, logic zf);
    bitmap_result_t r;
    r.index_ok   = ok;
    r.bit_value  = val;
    r.first_set  = IDX_W'(fs);
    r.set_found  = sf;
    r.first_zero = IDX_W'(fz);
    r.zero_found = zf;
    return r;
  endfunction

  task automatic note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] MISMATCH %s", $realtime, msg);
    end
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("** bitmap_set_clear_find_first_core: FAILED **");
      $finish;
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    out_if.ready <= no_idle || ($urandom_range(0, 99) >= 30);
  end

  // Check each result transfer against the oldest prediction
  always @(posedge clk) begin
    bitmap_result_t got;
    bitmap_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.index_ok   = out_if.index_ok;
      got.bit_value  = out_if.bit_value;
      got.first_set  = out_if.first_set;
      got.set_found  = out_if.set_found;
      got.first_zero = out_if.first_zero;
      got.zero_found = out_if.zero_found;
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result ok=%0b val=%0b fs=%0d/%0b fz=%0d/%0b",
                      got.index_ok, got.bit_value, got.first_set, got.set_found,
                      got.first_zero, got.zero_found));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.index_ok !== want.index_ok || got.bit_value !== want.bit_value ||
            got.first_set !== want.first_set || got.set_found !== want.set_found ||
            got.first_zero !== want.first_zero || got.zero_found !== want.zero_found) begin
          note_mismatch($sformatf(
            "result %0d: exp ok=%0b val=%0b fs=%0d/%0b fz=%0d/%0b, got ok=%0b val=%0b fs=%0d/%0b fz=%0d/%0b",
            results_checked, want.index_ok, want.bit_value, want.first_set, want.set_found,
            want.first_zero, want.zero_found, got.index_ok, got.bit_value, got.first_set,
            got.set_found, got.first_zero, got.zero_found));
        end
      end
    end
  end

  // Present one item, with random gaps ahead of it; valid stays high after the transfer
  task automatic send_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx, bit typed,
                           bitmap_result_t typed_result);
    bitmap_result_t predicted;
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < 30) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.bit_index <= idx;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predicted = predict_bit_access(op, idx);
    pending_results.push_back(typed ? typed_result : predicted);
    items_sent++;
  endtask

  // Drain, then write bits_in_use over APB and read it back
  task automatic write_bits_in_use(logic [CFG_W-1:0] value);
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BITS_IN_USE;
    pwdata  <= APB_DW'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    bits_in_use_shadow = value;
    cfg_writes++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[CFG_W-1:0] !== value) begin
      note_mismatch($sformatf("bits_in_use readback exp %0d got %0d", value,
                              prdata[CFG_W-1:0]));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Build the directed table
  task automatic add_row(row_kind_t kind, logic [OP_W-1:0] op, int arg, bit typed,
                         bitmap_result_t r);
    directed_row_t row;
    row.kind   = kind;
    row.op     = op;
    row.arg    = CFG_W'(arg);
    row.typed  = typed;
    row.result = r;
    directed_rows.push_back(row);
  endtask

  initial begin
    logic [CFG_W-1:0] phase_cfg [NUM_PHASES];
    bitmap_result_t   none;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    int used;
    int n_items;
    int r;

    none = '0;
    rst_n   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    in_if.valid     = 1'b0;
    in_if.operation = bscff_pkg::OP_TEST;
    in_if.bit_index = '0;
    out_if.ready    = 1'b0;
    no_idle = 1'b0;
    bitmap_shadow      = '0;
    bits_in_use_shadow = bscff_pkg::BITS_IN_USE_RST;

    // Reset state, extremes of the index, the undefined code, the test of bit 1023
    add_row(ROW_ITEM, bscff_pkg::OP_TEST, 0, 1, mk_result(1, 0, 0, 0, 0, 1));
    add_row(ROW_ITEM, bscff_pkg::OP_SET, 1023, 1, mk_result(1, 1, 1023, 1, 0, 1));
    add_row(ROW_ITEM, bscff_pkg::OP_SET, 0, 1, mk_result(1, 1, 0, 1, 1, 1));
    add_row(ROW_ITEM, OP_UNDEF, 0, 1, mk_result(1, 1, 0, 1, 1, 1));
    add_row(ROW_ITEM, bscff_pkg::OP_CLEAR, 0, 1, mk_result(1, 0, 1023, 1, 0, 1));
    add_row(ROW_ITEM, bscff_pkg::OP_TEST, 1023, 0, none);
    // Refused indices, then a map with no clear bit
    add_row(ROW_CFG, bscff_pkg::OP_TEST, 8, 0, none);
    add_row(ROW_ITEM, bscff_pkg::OP_SET, 8, 1, mk_result(0, 0, 0, 0, 0, 1));
    add_row(ROW_ITEM, bscff_pkg::OP_SET, 1023, 1, mk_result(0, 0, 0, 0, 0, 1));
    for (int i = 1; i < 8; i++) begin
      add_row(ROW_ITEM, bscff_pkg::OP_SET, i, 0, none);
    end
    add_row(ROW_ITEM, bscff_pkg::OP_SET, 0, 1, mk_result(1, 1, 0, 1, 0, 0));
    // Zero bits in use, then saturation above NBITS
    add_row(ROW_CFG, bscff_pkg::OP_TEST, 0, 0, none);
    add_row(ROW_ITEM, bscff_pkg::OP_TEST, 0, 1, mk_result(0, 0, 0, 0, 0, 0));
    add_row(ROW_CFG, bscff_pkg::OP_TEST, 2047, 0, none);
    add_row(ROW_ITEM, bscff_pkg::OP_TEST, 1023, 1, mk_result(1, 1, 0, 1, 8, 1));
    add_row(ROW_CFG, bscff_pkg::OP_TEST, 1024, 0, none);
    add_row(ROW_ITEM, bscff_pkg::OP_CLEAR, 1023, 0, none);
    add_row(ROW_ITEM, bscff_pkg::OP_CLEAR, 3, 0, none);

    phase_cfg = '{11'd16, 11'd1, 11'd64, 11'd65, 11'd1024, 11'd8, 11'd1023, 11'd2047,
                  11'd0, 11'd200, CFG_W'($urandom_range(2, 1024))};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part
    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_CFG) begin
        write_bits_in_use(directed_rows[k].arg);
      end else begin
        send_item(directed_rows[k].op, IDX_W'(directed_rows[k].arg), directed_rows[k].typed,
                  directed_rows[k].result);
      end
    end

    // Random part: per setting, fill the map first, then drain it
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_bits_in_use(phase_cfg[p]);
      no_idle = (p == 2);
      used = (int'(phase_cfg[p]) > NBITS) ? NBITS : int'(phase_cfg[p]);
      n_items = (used == 0) ? 15 : (used == 1) ? 30 : 90;
      for (int k = 0; k < n_items; k++) begin
        r = $urandom_range(0, 99);
        if (used == 0 || r < 12) begin
          idx = IDX_W'($urandom_range(0, 1023));
        end else if (r < 40) begin
          idx = IDX_W'($urandom_range(0, ((used < 16) ? used : 16) - 1));
        end else begin
          idx = IDX_W'($urandom_range(0, used - 1));
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
          op = (k < n_items / 2) ? bscff_pkg::OP_SET : bscff_pkg::OP_CLEAR;
        end else if (r < 90) begin
          op = (k < n_items / 2) ? bscff_pkg::OP_CLEAR : bscff_pkg::OP_SET;
        end else if (r < 95) begin
          op = bscff_pkg::OP_TEST;
        end else begin
          op = OP_UNDEF;
        end
        send_item(op, idx, 0, none);
      end
    end
    no_idle = 1'b0;

    // Drop valid, drain and watch for stray results
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
    if (pending_results.size() != 0) begin
      note_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    end

    $display("Covered %0d bit operations over %0d bits_in_use settings (0, 1, 8 to 2047);",
             items_sent, cfg_writes);
    $display("checked %0d results, %0d mismatches.", results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("** bitmap_set_clear_find_first_core: PASSED **");
    end else begin
      $display("** bitmap_set_clear_find_first_core: FAILED **");
    end
    $finish;
  end

endmodule
